[hdl/iea_pkg.sv]
// iea_pkg: shared widths, register indexes and defaults for the integer
// exponential approximation pipeline
// no dependencies
package iea_pkg;

    // field widths
    localparam int LOGIT_W  = 32;
    localparam int STEP_W   = 16;
    localparam int LIN_W    = 19;
    localparam int CONST_W  = 35;
    localparam int OUT_W    = 63;
    localparam int CFG_W    = 35;
    localparam int CFG_IDX_W = 2;

    // internal widths
    localparam int REM_W    = STEP_W;           // remainder and divisor magnitude
    localparam int SHAMT_W  = 6;                // shift amount, all ones means 63 or more
    localparam int RB_W     = LIN_W + 1;        // r + poly_linear
    localparam int PROD_W   = RB_W + STEP_W;    // (r + b) * r
    localparam int Z_W      = PROD_W + 1;       // polynomial value

    // divider layout: quotient bits resolved per pipeline stage
    localparam int DIV_STEP_BITS = 4;
    localparam int DIV_STAGES    = LOGIT_W / DIV_STEP_BITS;

    // default clamp range in ln2 steps
    localparam int SHIFT_RANGE_DEF = 30;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LN2_STEP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POLY_LINEAR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POLY_CONST  = 2'd2;

    // saturation value and shift code for out of range
    localparam logic [OUT_W-1:0]   OUT_MAX   = {OUT_W{1'b1}};
    localparam logic [SHAMT_W-1:0] SHAMT_SAT = {SHAMT_W{1'b1}};

endpackage

[hdl/integer_exp_approx.sv]
// integer_exp_approx: top level of the integer exponential approximation,
// configuration registers, stage valid tracking and the stream ports
// depends on iea_pkg, iea_prep, iea_div, iea_poly, iea_shift
//
// Usage:
//   s_ side takes one logit request per cycle on s_tdata (two's complement,
//   normally non-positive); m_ side returns one result per request, in order,
//   exp_value on m_tdata and the saturation flag on m_tuser.
//   Each request passes through 13 register stages: one clamp stage, eight
//   divider stages of four quotient bits each, one floor-correction stage,
//   two polynomial stages and the shift stage.
//   Throughput is one request per cycle while the output is not stalled;
//   the divider pipeline sets the depth.
//   Each stage holds its own valid bit, so when m_tready is low the pipeline
//   keeps filling empty stages and stops only when full; nothing is dropped.
//   Reset (aresetn low at a clock edge) empties the pipeline and loads the
//   registers with ln2_step = -1, poly_linear = 0, poly_const = 0.
//   Registers are written through cfg_wr_en / cfg_wr_index / cfg_wr_data
//   and should change only while no request is in flight.
module integer_exp_approx #(
    parameter int SHIFT_RANGE = iea_pkg::SHIFT_RANGE_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [iea_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [iea_pkg::CFG_W-1:0]         cfg_wr_data,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,   // [31:0] logit
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [63:0]                       m_tdata,   // [62:0] exp_value, [63] zero
    output logic                              m_tuser    // [0] saturated
);
    import iea_pkg::*;

    localparam int NUM_STAGES = DIV_STAGES + 5;

    // configuration registers
    logic signed [STEP_W-1:0]  ln2_step_reg, ln2_step_next;
    logic signed [LIN_W-1:0]   poly_linear_reg, poly_linear_next;
    logic signed [CONST_W-1:0] poly_const_reg, poly_const_next;

    always_comb begin
        ln2_step_next    = ln2_step_reg;
        poly_linear_next = poly_linear_reg;
        poly_const_next  = poly_const_reg;
        if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_LN2_STEP:    ln2_step_next    = cfg_wr_data[STEP_W-1:0];
                REG_POLY_LINEAR: poly_linear_next = cfg_wr_data[LIN_W-1:0];
                REG_POLY_CONST:  poly_const_next  = cfg_wr_data[CONST_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ln2_step_reg    <= '1;
            poly_linear_reg <= '0;
            poly_const_reg  <= '0;
        end else begin
            ln2_step_reg    <= ln2_step_next;
            poly_linear_reg <= poly_linear_next;
            poly_const_reg  <= poly_const_next;
        end
    end

    // stage valid bits and per-stage advance
    logic [NUM_STAGES-1:0] valid_reg, valid_next;
    logic [NUM_STAGES-1:0] stage_en;

    always_comb begin
        stage_en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_tready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            stage_en[i] = !valid_reg[i] || stage_en[i+1];
        end
        valid_next[0] = stage_en[0] ? s_tvalid : valid_reg[0];
        for (int i = 1; i < NUM_STAGES; i++) begin
            valid_next[i] = stage_en[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // divisor magnitude, step sanity; user keeps them stable in flight, unenforced
    logic [REM_W-1:0] divisor;
    logic             step_ok;

    assign divisor = REM_W'(-ln2_step_reg);
    assign step_ok = ln2_step_reg[STEP_W-1];

    // datapath
    logic [LOGIT_W-1:0]        mag;
    logic                      pos;
    logic signed [STEP_W-1:0]  rem;
    logic [SHAMT_W-1:0]        shamt_div, shamt_poly;
    logic signed [Z_W-1:0]     z;
    logic [OUT_W-1:0]          exp_value;
    logic                      saturated;

    iea_prep #(
        .SHIFT_RANGE (SHIFT_RANGE)
    ) u_prep (
        .aclk     (aclk),
        .en       (stage_en[0]),
        .logit    (s_tdata[LOGIT_W-1:0]),
        .ln2_step (ln2_step_reg),
        .mag      (mag),
        .pos      (pos)
    );

    iea_div #(
        .SHIFT_RANGE (SHIFT_RANGE)
    ) u_div (
        .aclk    (aclk),
        .en      (stage_en[DIV_STAGES+1:1]),
        .mag     (mag),
        .pos     (pos),
        .divisor (divisor),
        .rem     (rem),
        .shamt   (shamt_div)
    );

    iea_poly u_poly (
        .aclk        (aclk),
        .en          (stage_en[DIV_STAGES+3:DIV_STAGES+2]),
        .rem         (rem),
        .shamt_in    (shamt_div),
        .poly_linear (poly_linear_reg),
        .poly_const  (poly_const_reg),
        .z           (z),
        .shamt_out   (shamt_poly)
    );

    iea_shift u_shift (
        .aclk      (aclk),
        .en        (stage_en[NUM_STAGES-1]),
        .step_ok   (step_ok),
        .z         (z),
        .shamt     (shamt_poly),
        .exp_value (exp_value),
        .saturated (saturated)
    );

    // stream outputs
    assign s_tready = stage_en[0];
    assign m_tvalid = valid_reg[NUM_STAGES-1];
    assign m_tdata  = {1'b0, exp_value};
    assign m_tuser  = saturated;

endmodule

[hdl/iea_prep.sv]
// iea_prep: input stage, clamps the logit at the low bound and splits it into
// sign and magnitude for the divider
// depends on iea_pkg
module iea_prep #(
    parameter int SHIFT_RANGE = iea_pkg::SHIFT_RANGE_DEF
) (
    input  logic                                aclk,
    input  logic                                en,
    input  logic signed [iea_pkg::LOGIT_W-1:0]  logit,
    input  logic signed [iea_pkg::STEP_W-1:0]   ln2_step,
    output logic        [iea_pkg::LOGIT_W-1:0]  mag,
    output logic                                pos
);
    import iea_pkg::*;

    logic signed [LOGIT_W-1:0] low_bound;
    logic signed [LOGIT_W-1:0] clamped;
    logic [LOGIT_W-1:0]        mag_reg, mag_next;
    logic                      pos_reg, pos_next;

    // clamp below at the range times the step, then take magnitude
    always_comb begin
        low_bound = LOGIT_W'($signed(SHIFT_RANGE) * LOGIT_W'(ln2_step));
        clamped   = (logit < low_bound) ? low_bound : logit;
        pos_next  = !clamped[LOGIT_W-1] && (clamped != '0);
        mag_next  = clamped[LOGIT_W-1] ? LOGIT_W'(-clamped) : clamped;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg <= mag_next;
            pos_reg <= pos_next;
        end
    end

    assign mag = mag_reg;
    assign pos = pos_reg;

endmodule

[hdl/iea_div.sv]
// iea_div: pipelined restoring divider of the logit magnitude by the step
// magnitude, followed by a stage that forms the floor remainder and the shift
// depends on iea_pkg
module iea_div #(
    parameter int SHIFT_RANGE = iea_pkg::SHIFT_RANGE_DEF
) (
    input  logic                                   aclk,
    input  logic [iea_pkg::DIV_STAGES:0]           en,
    input  logic [iea_pkg::LOGIT_W-1:0]            mag,
    input  logic                                   pos,
    input  logic [iea_pkg::REM_W-1:0]              divisor,
    output logic signed [iea_pkg::STEP_W-1:0]      rem,
    output logic [iea_pkg::SHAMT_W-1:0]            shamt
);
    import iea_pkg::*;

    localparam int SW = LOGIT_W + 1;

    logic [REM_W-1:0]   rem_reg [DIV_STAGES];
    logic [LOGIT_W-1:0] nq_reg  [DIV_STAGES];
    logic               pos_reg [DIV_STAGES];

    // divider stages, each resolves DIV_STEP_BITS quotient bits
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [REM_W-1:0]   rem_in, rem_next;
        logic [LOGIT_W-1:0] nq_in, nq_next;
        logic               pos_in;
        logic [REM_W:0]     trial;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign nq_in  = mag;
            assign pos_in = pos;
        end else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign nq_in  = nq_reg[k-1];
            assign pos_in = pos_reg[k-1];
        end

        // dividend bits shift out at the top, quotient bits shift in below
        always_comb begin
            rem_next = rem_in;
            nq_next  = nq_in;
            trial    = '0;
            for (int i = 0; i < DIV_STEP_BITS; i++) begin
                trial   = {rem_next, nq_next[LOGIT_W-1]};
                nq_next = {nq_next[LOGIT_W-2:0], 1'b0};
                if (trial >= {1'b0, divisor}) begin
                    rem_next   = REM_W'(trial - {1'b0, divisor});
                    nq_next[0] = 1'b1;
                end else begin
                    rem_next = trial[REM_W-1:0];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en[k]) begin
                rem_reg[k] <= rem_next;
                nq_reg[k]  <= nq_next;
                pos_reg[k] <= pos_in;
            end
        end
    end

    logic [LOGIT_W-1:0]       quo;
    logic [REM_W-1:0]         rmag;
    logic                     rpos;
    logic [SW-1:0]            shift_wide;
    logic signed [STEP_W-1:0] rem_reg_o, rem_next_o;
    logic [SHAMT_W-1:0]       shamt_reg, shamt_next;

    // floor correction: positive logits round the quotient away from zero
    always_comb begin
        quo  = nq_reg[DIV_STAGES-1];
        rmag = rem_reg[DIV_STAGES-1];
        rpos = pos_reg[DIV_STAGES-1];
        if (rpos) begin
            shift_wide = SW'(SHIFT_RANGE) + {1'b0, quo} + SW'(rmag != '0);
            rem_next_o = (rmag == '0) ? '0
                         : STEP_W'({1'b0, rmag} - {1'b0, divisor});
        end else begin
            shift_wide = SW'(SHIFT_RANGE) - {1'b0, quo};
            rem_next_o = STEP_W'(-{1'b0, rmag});
        end
        shamt_next = (shift_wide >= SW'(SHAMT_SAT)) ? SHAMT_SAT
                                                   : shift_wide[SHAMT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en[DIV_STAGES]) begin
            rem_reg_o <= rem_next_o;
            shamt_reg <= shamt_next;
        end
    end

    assign rem   = rem_reg_o;
    assign shamt = shamt_reg;

endmodule

[hdl/iea_poly.sv]
// iea_poly: second-order polynomial (r + b) * r + c over two stages,
// multiply first and then the constant add
// depends on iea_pkg
module iea_poly (
    input  logic                                  aclk,
    input  logic [1:0]                            en,
    input  logic signed [iea_pkg::STEP_W-1:0]     rem,
    input  logic [iea_pkg::SHAMT_W-1:0]           shamt_in,
    input  logic signed [iea_pkg::LIN_W-1:0]      poly_linear,
    input  logic signed [iea_pkg::CONST_W-1:0]    poly_const,
    output logic signed [iea_pkg::Z_W-1:0]        z,
    output logic [iea_pkg::SHAMT_W-1:0]           shamt_out
);
    import iea_pkg::*;

    logic signed [RB_W-1:0]   rb;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [SHAMT_W-1:0]       sh1_reg;
    logic signed [Z_W-1:0]    z_reg, z_next;
    logic [SHAMT_W-1:0]       sh2_reg;

    // product stage
    always_comb begin
        rb        = RB_W'(poly_linear) + RB_W'(rem);
        prod_next = PROD_W'(rb) * PROD_W'(rem);
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            prod_reg <= prod_next;
            sh1_reg  <= shamt_in;
        end
    end

    // constant term
    assign z_next = Z_W'(prod_reg) + Z_W'(poly_const);

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            z_reg   <= z_next;
            sh2_reg <= sh1_reg;
        end
    end

    assign z         = z_reg;
    assign shamt_out = sh2_reg;

endmodule

[hdl/iea_shift.sv]
// iea_shift: output stage, scales the polynomial by the power of two,
// clamps at zero, gives zero for a non-negative step and saturates at the output range
// depends on iea_pkg
module iea_shift (
    input  logic                               aclk,
    input  logic                               en,
    input  logic                               step_ok,
    input  logic signed [iea_pkg::Z_W-1:0]     z,
    input  logic [iea_pkg::SHAMT_W-1:0]        shamt,
    output logic [iea_pkg::OUT_W-1:0]          exp_value,
    output logic                               saturated
);
    import iea_pkg::*;

    localparam int WIDE_W = (Z_W - 1) + (OUT_W - 1);

    logic [WIDE_W-1:0] wide;
    logic              z_pos;
    logic              over;
    logic [OUT_W-1:0]  val_reg, val_next;
    logic              sat_reg, sat_next;

    // shift and check for bits past the output range
    always_comb begin
        z_pos = !z[Z_W-1] && (z != '0);
        wide  = WIDE_W'(z[Z_W-2:0]) << shamt;
        over  = (shamt == SHAMT_SAT) || (|wide[WIDE_W-1:OUT_W]);
        if (!step_ok || !z_pos) begin
            val_next = '0;
            sat_next = 1'b0;
        end else if (over) begin
            val_next = OUT_MAX;
            sat_next = 1'b1;
        end else begin
            val_next = wide[OUT_W-1:0];
            sat_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            val_reg <= val_next;
            sat_reg <= sat_next;
        end
    end

    assign exp_value = val_reg;
    assign saturated = sat_reg;

endmodule
